// File: rtl/core/jaf_pkg.sv
// shared types and constants for the joystick axis filter and framer
package jaf_pkg;

	localparam int AXES        = 2;
	localparam int SAMPLE_W    = 12;
	localparam int CENTER_W    = 12;
	localparam int DEAD_W      = 8;
	localparam int ENTRY_W     = 9;
	localparam int BYTE_W      = 8;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 12;

	localparam logic [CENTER_W-1:0] CENTER_RESET = 12'd2048;
	localparam logic [DEAD_W-1:0]   DEAD_RESET   = 8'd30;
	localparam logic [BYTE_W-1:0]   FRAME_TAIL   = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_OFFSET = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEAD_ZONE     = 1'd1;

	typedef logic signed [ENTRY_W-1:0] entry_t;

	typedef enum logic [1:0] {
		BYTE_AXIS,
		BYTE_LOW,
		BYTE_HIGH,
		BYTE_TAIL
	} byte_sel_t;

	typedef struct packed {
		logic              axis;
		logic [BYTE_W-1:0] avg_low;
		logic [BYTE_W-1:0] avg_high;
	} frame_t;

endpackage

// File: rtl/core/jaf_if.sv
// stream interfaces for joystick samples and frame bytes
interface jaf_sample_if;
	logic        valid;
	logic        ready;
	logic        axis;
	logic [11:0] sample;

	modport source (output valid, output axis, output sample, input ready);
	modport sink (input valid, input axis, input sample, output ready);
endinterface

interface jaf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last;

	modport source (output valid, output frame_byte, output last, input ready);
	modport sink (input valid, input frame_byte, input last, output ready);
endinterface

// File: rtl/core/jaf_cell.sv
// one window cell: holds one entry per axis and takes its neighbour's entry on a shift
module jaf_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic                      axis,
	input  jaf_pkg::entry_t           din,
	output jaf_pkg::entry_t [1:0]     entries
);
	import jaf_pkg::*;

	entry_t [1:0] entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (shift) begin
			entry_q[axis] <= din;
		end
	end

	assign entries = entry_q;

endmodule

// File: rtl/core/jaf_framer.sv
// byte serialiser: turns one averaged result into a four-byte frame
module jaf_framer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load_valid,
	input  jaf_pkg::frame_t  load_data,
	output logic             load_ready,
	jaf_byte_if.source       out_ch
);
	import jaf_pkg::*;

	frame_t    frame_q;
	byte_sel_t sel_q;
	logic      busy_q;
	logic      out_fire;
	logic      load;

	assign out_fire   = busy_q && out_ch.ready;
	// a new frame may load while the tail byte is leaving
	assign load_ready = !busy_q || (out_fire && sel_q == BYTE_TAIL);
	assign load       = load_valid && load_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sel_q  <= BYTE_AXIS;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				sel_q  <= BYTE_AXIS;
			end else if (out_fire) begin
				if (sel_q == BYTE_TAIL) begin
					busy_q <= 1'b0;
				end
				sel_q <= byte_sel_t'(sel_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= load_data;
		end
	end

	always_comb begin
		case (sel_q)
			BYTE_AXIS: out_ch.frame_byte = {{(BYTE_W-1){1'b0}}, frame_q.axis};
			BYTE_LOW:  out_ch.frame_byte = frame_q.avg_low;
			BYTE_HIGH: out_ch.frame_byte = frame_q.avg_high;
			BYTE_TAIL: out_ch.frame_byte = FRAME_TAIL;
			default:   out_ch.frame_byte = FRAME_TAIL;
		endcase
	end

	assign out_ch.valid = busy_q;
	assign out_ch.last  = (sel_q == BYTE_TAIL);

endmodule

// File: rtl/core/joystick_axis_filter_framer.sv
// joystick axis filter: centre, scale, dead zone, per-axis moving average, byte framer
//
// in_ch carries one 12-bit ADC sample with its axis bit; out_ch carries the
// resulting frame one byte per transaction: axis, average low byte, average
// high byte (sign carried), 0xFF with last set.
// cfg writes centre offset (index 0) and dead zone (index 1); the user must write
// them only while idle, which the block does not enforce. a frame's first byte is
// valid once its sample has passed the conditioning, window update, multiply and
// scale registers and the serialiser load. the four-byte serialiser sets the
// sustained rate; the four-stage pipeline takes samples back to back until it fills.
// the window is a row of WINDOW_LEN cells, each holding one entry per axis,
// that shift on each sample of that axis, with a running sum per axis; the
// average uses a reciprocal multiply.
// when the receiver stalls, the serialiser holds its byte, the pipeline stops
// and in_ch.ready falls; nothing is dropped.
// reset clears the windows, the sums and the pipeline, and loads the
// registers with centre 2048 and dead zone 30.
module joystick_axis_filter_framer #(
	parameter int WINDOW_LEN = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [jaf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [jaf_pkg::CFG_DATA_W-1:0]     cfg_data,
	jaf_sample_if.sink                         in_ch,
	jaf_byte_if.source                         out_ch
);
	import jaf_pkg::*;

	localparam int LOG_LEN   = $clog2(WINDOW_LEN);
	localparam int SUM_W     = ENTRY_W + LOG_LEN;
	localparam int DIV_SHIFT = SUM_W + LOG_LEN;
	localparam int DIV_MUL_I = ((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
	localparam int PROD_W    = 2 * SUM_W + 1;
	localparam logic [SUM_W:0] DIV_MUL = (SUM_W + 1)'(DIV_MUL_I);

	logic [CENTER_W-1:0] center_q;
	logic [DEAD_W-1:0]   dead_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RESET;
			dead_q   <= DEAD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_OFFSET: center_q <= cfg_data[CENTER_W-1:0];
				CFG_DEAD_ZONE:     dead_q   <= cfg_data[DEAD_W-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance
	logic   adv;
	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	logic   load_ready;
	frame_t frame_s4;

	assign adv         = !valid_s4 || load_ready;
	assign in_ch.ready = adv;

	// sample conditioning
	logic signed [12:0] centered;
	logic signed [12:0] biased;
	logic signed [12:0] shifted;
	logic signed [9:0]  reduced;
	logic [9:0]         reduced_mag;
	entry_t             cond;

	always_comb begin
		centered    = $signed({1'b0, in_ch.sample}) - $signed({1'b0, center_q});
		// bias negatives so the shift truncates toward zero
		biased      = centered[12] ? centered + 13'sd7 : centered;
		shifted     = biased >>> 3;
		reduced     = shifted[9:0];
		reduced_mag = reduced[9] ? 10'(-reduced) : 10'(reduced);
		if (reduced_mag <= {2'b00, dead_q}) begin
			cond = '0;
		end else if (reduced < -10'sd256) begin
			cond = -9'sd256;
		end else if (reduced > 10'sd255) begin
			cond = 9'sd255;
		end else begin
			cond = reduced[8:0];
		end
	end

	entry_t v_s1;
	logic   axis_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1    <= cond;
			axis_s1 <= in_ch.axis;
		end
	end

	// window: row of cells, the last one holds the oldest entry
	logic         shift;
	entry_t [1:0] chain [WINDOW_LEN];
	entry_t       evicted;

	assign shift   = valid_s1 && adv;
	assign evicted = chain[WINDOW_LEN-1][axis_s1];

	for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
		entry_t din;
		if (i == 0) begin : g_head
			assign din = v_s1;
		end else begin : g_link
			assign din = chain[i-1][axis_s1];
		end
		jaf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.axis    (axis_s1),
			.din     (din),
			.entries (chain[i])
		);
	end

	logic signed [SUM_W-1:0] sum_q [AXES];
	logic signed [SUM_W-1:0] new_sum;
	logic signed [SUM_W-1:0] sum_s2;
	logic                    axis_s2;

	assign new_sum = sum_q[axis_s1] - SUM_W'(evicted) + SUM_W'(v_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0] <= '0;
			sum_q[1] <= '0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				sum_q[axis_s1] <= new_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2  <= new_sum;
			axis_s2 <= axis_s1;
		end
	end

	// average: magnitude times reciprocal, then shift and restore sign
	logic [SUM_W-1:0]  sum_mag;
	logic [PROD_W-1:0] prod_s3;
	logic              neg_s3;
	logic              axis_s3;

	assign sum_mag = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= PROD_W'(sum_mag) * PROD_W'(DIV_MUL);
			neg_s3  <= sum_s2[SUM_W-1];
			axis_s3 <= axis_s2;
		end
	end

	logic [SUM_W-1:0]        quot;
	logic signed [SUM_W-1:0] avg;
	logic signed [15:0]      avg_wide;

	assign quot     = SUM_W'(prod_s3 >> DIV_SHIFT);
	assign avg      = neg_s3 ? $signed(SUM_W'(-quot)) : $signed(quot);
	assign avg_wide = 16'(avg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_s4.axis     <= axis_s3;
			frame_s4.avg_low  <= avg_wide[7:0];
			frame_s4.avg_high <= avg_wide[15:8];
		end
	end

	jaf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s4),
		.load_data  (frame_s4),
		.load_ready (load_ready),
		.out_ch     (out_ch)
	);

endmodule

// File: dv/tb.sv
// testbench for the joystick axis filter and framer: directed and random samples, frame checks
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import jaf_pkg::*;

	localparam int WINDOW_LEN   = 5;
	localparam int DRAIN_CYCLES = 16;
	localparam int RANDOM_ITEMS = 150;

	// expected frames, built from the filter state kept alongside the block
	class frame_checker #(int LEN = 5);
		typedef struct {
			logic [BYTE_W-1:0] fbyte;
			logic              last;
		} frame_beat_t;

		frame_beat_t         pending_beats[$];
		logic [CENTER_W-1:0] center;
		logic [DEAD_W-1:0]   dead;
		entry_t              window[AXES][LEN];
		int                  axis_sum[AXES];
		int                  next_slot[AXES];
		int                  mismatches;

		function new();
			center = CENTER_RESET;
			dead   = DEAD_RESET;
			foreach (window[a, i])
				window[a][i] = '0;
			foreach (axis_sum[a]) begin
				axis_sum[a]  = 0;
				next_slot[a] = 0;
			end
			mismatches = 0;
		endfunction

		function void set_config(logic [CENTER_W-1:0] c, logic [DEAD_W-1:0] d);
			center = c;
			dead   = d;
		endfunction

		// centre, divide by 8 toward zero, dead zone, then clamp to the cell width
		function entry_t reduce_sample(logic [SAMPLE_W-1:0] raw);
			int centred;
			int reduced;
			centred = int'(raw) - int'(center);
			reduced = centred / 8;
			if (reduced >= -int'(dead) && reduced <= int'(dead))
				reduced = 0;
			if (reduced < -256)
				reduced = -256;
			if (reduced > 255)
				reduced = 255;
			return entry_t'(reduced);
		endfunction

		function int filtered_average(logic ax, logic [SAMPLE_W-1:0] raw);
			entry_t v;
			int     s;
			v = reduce_sample(raw);
			s = next_slot[ax];
			axis_sum[ax] = axis_sum[ax] - int'(window[ax][s]) + int'(v);
			window[ax][s] = v;
			next_slot[ax] = (s + 1 >= LEN) ? 0 : s + 1;
			return axis_sum[ax] / LEN;
		endfunction

		function void note_sample(logic ax, logic [SAMPLE_W-1:0] raw);
			int          avg;
			frame_beat_t beat;
			byte_sel_t   sel;
			avg = filtered_average(ax, raw);
			sel = BYTE_AXIS;
			for (int i = 0; i < 4; i++) begin
				case (sel)
					BYTE_AXIS: beat.fbyte = {7'd0, ax};
					BYTE_LOW:  beat.fbyte = avg[7:0];
					BYTE_HIGH: beat.fbyte = 8'(avg >>> 8);
					default:   beat.fbyte = FRAME_TAIL;
				endcase
				beat.last = (sel == BYTE_TAIL);
				pending_beats.push_back(beat);
				sel = sel.next();
			end
		endfunction

		function int pending();
			return pending_beats.size();
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_byte(logic [BYTE_W-1:0] b, logic l);
			frame_beat_t want;
			if (pending_beats.size() == 0) begin
				report($sformatf("unexpected byte %02h last %0b", b, l));
			end else begin
				want = pending_beats.pop_front();
				if (b !== want.fbyte)
					report($sformatf("frame byte %02h, wanted %02h", b, want.fbyte));
				if (l !== want.last)
					report($sformatf("last %0b, wanted %0b", l, want.last));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	jaf_sample_if sample_ch();
	jaf_byte_if   byte_ch();

	frame_checker #(WINDOW_LEN) scb;

	int send_gap_max;
	int recv_stall_max;

	always #4 clk = ~clk;

	joystick_axis_filter_framer #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (sample_ch),
		.out_ch   (byte_ch)
	);

	// called only while the block is idle
	task write_regs(logic [CENTER_W-1:0] c, logic [DEAD_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CENTER_OFFSET;
		cfg_data  <= c;
		@(posedge clk);
		cfg_index <= CFG_DEAD_ZONE;
		cfg_data  <= CFG_DATA_W'(d);
		@(posedge clk);
		cfg_we    <= 1'b0;
		scb.set_config(c, d);
	endtask

	task wait_idle();
		sample_ch.valid <= 1'b0;
		while (scb.pending() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task send_sample(logic ax, logic [SAMPLE_W-1:0] raw);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.axis   <= ax;
		sample_ch.sample <= raw;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		scb.note_sample(ax, raw);
	endtask

	// mix of uniform codes, near-centre codes, dead zone edges and rails
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int kind;
		int v;
		int edge_dist;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			v = int'($urandom_range(0, 4095));
		end else if (kind < 7) begin
			v = int'(scb.center) + int'($urandom_range(0, 600)) - 300;
		end else if (kind < 9) begin
			edge_dist = 8 * int'(scb.dead) + int'($urandom_range(0, 15));
			v = int'(scb.center) + ($urandom_range(0, 1) ? edge_dist : -edge_dist);
		end else begin
			v = $urandom_range(0, 1) ? 4095 : 0;
		end
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return SAMPLE_W'(v);
	endfunction

	initial begin
		int             stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, recv_stall_max);
			if (stall > 0) begin
				byte_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			byte_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!byte_ch.valid);
			scb.check_byte(byte_ch.frame_byte, byte_ch.last);
		end
	end

	initial begin
		logic [CENTER_W-1:0] c;
		logic [DEAD_W-1:0]   d;
		scb              = new();
		send_gap_max     = 3;
		recv_stall_max   = 3;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_CENTER_OFFSET;
		cfg_data         <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.axis   <= 1'b0;
		sample_ch.sample <= '0;
		byte_ch.ready    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: centre, dead zone edges either side, rails
		send_sample(1'b0, 12'd2048);
		send_sample(1'b0, 12'd2295);
		send_sample(1'b0, 12'd2296);
		send_sample(1'b0, 12'd1800);
		send_sample(1'b0, 12'd1801);
		send_sample(1'b1, 12'd0);
		send_sample(1'b1, 12'd4095);
		wait_idle();

		// no offset, no dead zone: positive saturation and truncation toward zero
		write_regs(12'd0, 8'd0);
		send_sample(1'b0, 12'd4095);
		send_sample(1'b1, 12'd7);
		send_sample(1'b1, 12'd8);
		wait_idle();

		// top offset, widest dead zone: negative saturation
		write_regs(12'd4095, 8'd255);
		send_sample(1'b1, 12'd0);
		send_sample(1'b1, 12'd4095);
		send_sample(1'b0, 12'd2055);
		send_sample(1'b0, 12'd2047);
		wait_idle();

		// flush Y to zero, then small negative averages carrying the sign
		write_regs(12'd2048, 8'd0);
		repeat (WINDOW_LEN) send_sample(1'b1, 12'd2048);
		send_sample(1'b1, 12'd2008);
		send_sample(1'b1, 12'd2040);
		send_sample(1'b1, 12'd2047);
		wait_idle();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin c = 12'($urandom_range(0, 4095)); d = 8'($urandom_range(0, 255)); end
				1: begin c = 12'd0;    d = 8'd0;   end
				2: begin c = 12'd4095; d = 8'd255; end
				3: begin c = 12'd2048; d = 8'd30;  end
				default: begin
					c = 12'($urandom_range(1500, 2600));
					d = 8'($urandom_range(0, 60));
				end
			endcase
			write_regs(c, d);
			case (phase)
				0: begin send_gap_max = 14; recv_stall_max = 14; end
				1: begin send_gap_max = 0;  recv_stall_max = 0;  end
				2: begin send_gap_max = 14; recv_stall_max = 0;  end
				3: begin send_gap_max = 0;  recv_stall_max = 14; end
				default: begin send_gap_max = 5; recv_stall_max = 9; end
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 5; n++)
				send_sample(1'($urandom_range(0, 1)), pick_sample());
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
